// ===== src/tall_pkg.sv =====
// Shared constants and register codes for the lateral acceleration limiter and low-pass.
package tall_pkg;

	// Q7.8 fraction bits of speed, turn rate, limit and threshold
	localparam int DATA_FRAC_BITS = 8;

	// Register widths
	localparam int LIMIT_W    = 15;
	localparam int GAIN_W     = 16;
	localparam int THRESH_W   = 15;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 2;

	// Limit scaled to the Q.16 format of a speed * turn product
	localparam int LIM_SCALED_W = LIMIT_W + DATA_FRAC_BITS;

	// Reset values: limit 5.0, threshold one LSB
	localparam logic [LIMIT_W-1:0]  ACCEL_LIMIT_RESET = 15'd1280;
	localparam logic [THRESH_W-1:0] THRESH_RESET      = 15'd1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ACCEL_LIMIT          = 2'd0,
		REG_SPEED_GAIN           = 2'd1,
		REG_TURN_GAIN            = 2'd2,
		REG_SMALL_TURN_THRESHOLD = 2'd3
	} cfg_reg_t;

endpackage

// ===== src/tall_if.sv =====
// Valid/ready channels for command items and result items.
interface tall_cmd_if #(parameter int DATA_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] linear_speed;
	logic signed [DATA_WIDTH-1:0] turn_rate;

	modport source (output valid, linear_speed, turn_rate, input ready);
	modport sink (input valid, linear_speed, turn_rate, output ready);
endinterface

interface tall_res_if #(parameter int DATA_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] filtered_speed;
	logic signed [DATA_WIDTH-1:0] filtered_turn_rate;

	modport source (output valid, filtered_speed, filtered_turn_rate, input ready);
	modport sink (input valid, filtered_speed, filtered_turn_rate, output ready);
endinterface

// ===== src/tall_mul.sv =====
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier.
module tall_mul #(
	parameter int A_W = 17,
	parameter int B_W = 17
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [A_W-1:0]    a,
	input  logic [B_W-1:0]           b,
	output logic                     done,
	output logic signed [A_W+B_W-1:0] prod
);

	localparam int CNT_W = $clog2(B_W + 1);

	logic signed [A_W-1:0] a_q;
	logic signed [A_W:0]   hi_q;
	logic [B_W-1:0]        lo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic signed [A_W:0]   a_ext;
	logic signed [A_W:0]   sum;

	// one multiplier bit per cycle, LSB first
	assign a_ext = (A_W+1)'(a_q);
	assign sum   = lo_q[0] ? (hi_q + a_ext) : hi_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulator and multiplier shift register
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = $signed({hi_q[A_W-1:0], lo_q});

endmodule

// ===== src/tall_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module tall_div #(
	parameter int N_W = 23,
	parameter int D_W = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [D_W-1:0]   dvs_q;
	logic [D_W-1:0]   rem_q;
	logic [N_W-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     trial;
	logic [D_W:0]     diff;
	logic             fits;

	// remainder stays below the divisor, so a set MSB means a borrow
	assign trial = {rem_q, quo_q[N_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = !diff[D_W];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/twist_accel_limit_lowpass.sv =====
// Top level: lateral acceleration limit on a speed/turn command, then two first-order low-passes.
// A limited item runs |v|*|w| and the turn filter product, then the divider, then the speed filter product;
// an item within the limit skips the divider. Multiplier operand width B = max(DATA_WIDTH, GAIN_FRAC_BITS+1).
// A small-turn item passes through unfiltered, via the result registers and then the output register.
// One item at a time; the next is taken once the result has entered the output register and the
// sequencer is back in idle.
// Reset (arst_n low) restores the register defaults and clears both filter states to zero.
module twist_accel_limit_lowpass #(
	parameter int DATA_WIDTH     = 16,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tall_pkg::CFG_INDEX_W-1:0]    cfg_addr,
	input  logic [tall_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	tall_cmd_if.sink                            cmd,
	tall_res_if.source                          res
);

	localparam int DW     = DATA_WIDTH;
	localparam int GF     = GAIN_FRAC_BITS;
	localparam int A_W    = DW + 1;
	localparam int B_W    = (DW > GF + 1) ? DW : GF + 1;
	localparam int P_W    = A_W + B_W;
	localparam int LSW    = tall_pkg::LIM_SCALED_W;
	localparam int CMP_W  = (P_W > LSW) ? P_W : LSW;
	localparam int GC_W   = (tall_pkg::GAIN_W > GF + 1) ? tall_pkg::GAIN_W : GF + 1;
	localparam int THC_W  = (DW > tall_pkg::THRESH_W) ? DW : tall_pkg::THRESH_W;
	localparam int SQ_W   = ((LSW > DW) ? LSW : DW) + 1;
	localparam int F_W    = DW + 2;

	localparam logic [GC_W-1:0] G_ONE = GC_W'(1) << GF;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_FGO  = 6'b001000,
		ST_FILT = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	// saturate a filter sum to the data range
	function automatic logic signed [DW-1:0] sat_f(input logic signed [F_W-1:0] x);
		logic [F_W-DW:0] hi_bits;
		hi_bits = x[F_W-1:DW-1];
		if (hi_bits == '0 || hi_bits == '1)
			sat_f = x[DW-1:0];
		else if (x[F_W-1])
			sat_f = {1'b1, {(DW-1){1'b0}}};
		else
			sat_f = {1'b0, {(DW-1){1'b1}}};
	endfunction

	// saturate a signed quotient to the data range
	function automatic logic signed [DW-1:0] sat_q(input logic signed [SQ_W-1:0] x);
		logic [SQ_W-DW:0] hi_bits;
		hi_bits = x[SQ_W-1:DW-1];
		if (hi_bits == '0 || hi_bits == '1)
			sat_q = x[DW-1:0];
		else if (x[SQ_W-1])
			sat_q = {1'b1, {(DW-1){1'b0}}};
		else
			sat_q = {1'b0, {(DW-1){1'b1}}};
	endfunction

	// configuration registers
	logic [tall_pkg::LIMIT_W-1:0]  accel_limit_q;
	logic [tall_pkg::GAIN_W-1:0]   speed_gain_q;
	logic [tall_pkg::GAIN_W-1:0]   turn_gain_q;
	logic [tall_pkg::THRESH_W-1:0] thresh_q;

	// control and state
	state_t                state_q;
	logic signed [DW-1:0]  speed_y_q;
	logic signed [DW-1:0]  turn_y_q;
	logic signed [DW-1:0]  v_q;
	logic signed [DW-1:0]  w_q;
	logic [DW-1:0]         aw_q;
	logic signed [DW-1:0]  sp_q;
	logic signed [DW-1:0]  res_speed_q;
	logic signed [DW-1:0]  res_turn_q;
	logic                  out_valid_q;
	logic signed [DW-1:0]  out_speed_q;
	logic signed [DW-1:0]  out_turn_q;

	// datapath signals
	logic                  cmd_fire;
	logic [DW-1:0]         v_bits;
	logic [DW-1:0]         w_bits;
	logic [DW-1:0]         av_in;
	logic [DW-1:0]         aw_in;
	logic                  bypass_in;
	logic [GC_W-1:0]       gs_ext;
	logic [GC_W-1:0]       gt_ext;
	logic [GC_W-1:0]       gs_cl;
	logic [GC_W-1:0]       gt_cl;
	logic [B_W-1:0]        g_s;
	logic [B_W-1:0]        g_t;
	logic signed [A_W-1:0] d_t;
	logic signed [A_W-1:0] d_s;
	logic [LSW-1:0]        lim_scaled;

	logic                  mul_s_start;
	logic signed [A_W-1:0] mul_s_a;
	logic [B_W-1:0]        mul_s_b;
	logic                  mul_s_done;
	logic signed [P_W-1:0] mul_s_prod;
	logic                  mul_t_start;
	logic                  mul_t_done;
	logic signed [P_W-1:0] mul_t_prod;
	logic                  div_start;
	logic                  div_done;
	logic [LSW-1:0]        div_quo;

	logic [P_W-1:0]        prod_mag;
	logic                  over;
	logic signed [SQ_W-1:0] q_signed;
	logic signed [P_W-1:0] s_shift;
	logic signed [P_W-1:0] t_shift;
	logic signed [F_W-1:0] s_sum;
	logic signed [F_W-1:0] t_sum;
	logic signed [DW-1:0]  speed_new;
	logic signed [DW-1:0]  turn_new;
	logic                  slot_free;
	logic                  load_out;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_limit_q <= tall_pkg::ACCEL_LIMIT_RESET;
			speed_gain_q  <= '0;
			turn_gain_q   <= '0;
			thresh_q      <= tall_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			unique case (tall_pkg::cfg_reg_t'(cfg_addr))
				tall_pkg::REG_ACCEL_LIMIT: accel_limit_q <= cfg_wdata[tall_pkg::LIMIT_W-1:0];
				tall_pkg::REG_SPEED_GAIN: speed_gain_q <= cfg_wdata[tall_pkg::GAIN_W-1:0];
				tall_pkg::REG_TURN_GAIN: turn_gain_q <= cfg_wdata[tall_pkg::GAIN_W-1:0];
				tall_pkg::REG_SMALL_TURN_THRESHOLD: thresh_q <= cfg_wdata[tall_pkg::THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// input magnitudes and small-turn test
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign v_bits    = cmd.linear_speed;
	assign w_bits    = cmd.turn_rate;
	assign av_in     = v_bits[DW-1] ? (~v_bits + DW'(1)) : v_bits;
	assign aw_in     = w_bits[DW-1] ? (~w_bits + DW'(1)) : w_bits;
	assign bypass_in = THC_W'(aw_in) < THC_W'(thresh_q);

	// gains clamped to one
	assign gs_ext = GC_W'(speed_gain_q);
	assign gt_ext = GC_W'(turn_gain_q);
	assign gs_cl  = (gs_ext > G_ONE) ? G_ONE : gs_ext;
	assign gt_cl  = (gt_ext > G_ONE) ? G_ONE : gt_ext;
	assign g_s    = B_W'(gs_cl[GF:0]);
	assign g_t    = B_W'(gt_cl[GF:0]);

	// low-pass as y' = x + floor(g*(y-x) / 2^GF)
	assign d_t = A_W'(turn_y_q) - A_W'(cmd.turn_rate);
	assign d_s = A_W'(speed_y_q) - A_W'(sp_q);

	assign lim_scaled = {accel_limit_q, {tall_pkg::DATA_FRAC_BITS{1'b0}}};

	// speed unit: |v|*|w| first, then the speed filter product
	assign mul_s_start = (cmd_fire && !bypass_in) || (state_q == ST_FGO);
	assign mul_s_a     = (state_q == ST_FGO) ? d_s : $signed({1'b0, av_in});
	assign mul_s_b     = (state_q == ST_FGO) ? g_s : B_W'(aw_in);
	assign mul_t_start = cmd_fire && !bypass_in;

	tall_mul #(.A_W(A_W), .B_W(B_W)) u_mul_s (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_s_start),
		.a      (mul_s_a),
		.b      (mul_s_b),
		.done   (mul_s_done),
		.prod   (mul_s_prod)
	);

	tall_mul #(.A_W(A_W), .B_W(B_W)) u_mul_t (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_t_start),
		.a      (d_t),
		.b      (g_t),
		.done   (mul_t_done),
		.prod   (mul_t_prod)
	);

	// limit compare on the product magnitude
	assign prod_mag  = mul_s_prod;
	assign over      = CMP_W'(prod_mag) > CMP_W'(lim_scaled);
	assign div_start = (state_q == ST_MUL) && mul_s_done && over;

	tall_div #(.N_W(LSW), .D_W(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lim_scaled),
		.divisor  (aw_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// quotient takes the sign of the turn rate
	assign q_signed = w_q[DW-1] ? (~SQ_W'(div_quo) + SQ_W'(1)) : SQ_W'(div_quo);

	// filter outputs
	assign s_shift   = mul_s_prod >>> GF;
	assign t_shift   = mul_t_prod >>> GF;
	assign s_sum     = F_W'(sp_q) + F_W'(s_shift);
	assign t_sum     = F_W'(w_q) + F_W'(t_shift);
	assign speed_new = sat_f(s_sum);
	assign turn_new  = sat_f(t_sum);

	assign slot_free = !out_valid_q || res.ready;
	assign load_out  = (state_q == ST_DONE) && slot_free;

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			speed_y_q <= '0;
			turn_y_q  <= '0;
		end else begin
			if (mul_t_done)
				turn_y_q <= turn_new;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire)
						state_q <= bypass_in ? ST_DONE : ST_MUL;
				end
				ST_MUL: begin
					if (mul_s_done)
						state_q <= over ? ST_DIV : ST_FGO;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_FGO;
				end
				ST_FGO: state_q <= ST_FILT;
				ST_FILT: begin
					if (mul_s_done) begin
						speed_y_q <= speed_new;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture, limited speed and pending result
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			v_q  <= cmd.linear_speed;
			w_q  <= cmd.turn_rate;
			aw_q <= aw_in;
			if (bypass_in) begin
				res_speed_q <= cmd.linear_speed;
				res_turn_q  <= cmd.turn_rate;
			end
		end
		if ((state_q == ST_MUL) && mul_s_done && !over)
			sp_q <= v_q;
		if (div_done)
			sp_q <= sat_q(q_signed);
		if ((state_q == ST_FILT) && mul_s_done) begin
			res_speed_q <= speed_new;
			res_turn_q  <= turn_y_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_speed_q <= res_speed_q;
			out_turn_q  <= res_turn_q;
		end
	end

	assign cmd.ready              = (state_q == ST_IDLE);
	assign res.valid              = out_valid_q;
	assign res.filtered_speed     = out_speed_q;
	assign res.filtered_turn_rate = out_turn_q;

	// a small-turn item leaves both filter states untouched
	a_bypass_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && bypass_in) |=> ($stable(speed_y_q) && $stable(turn_y_q)))
		else $error("filter state changed on a small-turn item");

	// the turn multiplier starts with the speed unit's |v|*|w| pass and must finish with it
	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mul_t_done |-> (mul_s_done && state_q == ST_MUL))
		else $error("turn filter product out of step with speed unit");

	// speed unit completes only while the sequencer waits on it
	a_mul_s_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_s_done |-> (state_q == ST_MUL || state_q == ST_FILT))
		else $error("speed multiplier finished in an unexpected state");

	// divider completes only in its own state
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// limited speed carries the sign of the turn rate
	a_limit_sign: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |=> ((sp_q[DW-1] == w_q[DW-1]) || (sp_q == '0)))
		else $error("limited speed has the wrong sign");

endmodule
